[rtl/nkvt_pkg.sv]
// ---------------------------------------------------------------------------
// nkvt_pkg: shared types for the name keyed value table
// item layouts, status codes, cell token and query bundles, control states
// ---------------------------------------------------------------------------
package nkvt_pkg;

  localparam int KEY_WORDS = 4;
  localparam int KEY_W     = 64 * KEY_WORDS;
  localparam int VALUE_W   = 64;
  localparam int ENTRY_W   = 7;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_UPDATED = 3'd1,
    ST_INVALID = 3'd2,
    ST_FULL    = 3'd3,
    ST_HIT     = 3'd4,
    ST_MISS    = 3'd5
  } status_t;

  typedef struct packed {
    logic        op;
    logic [63:0] key_word0;
    logic [63:0] key_word1;
    logic [63:0] key_word2;
    logic [63:0] key_word3;
    logic [63:0] new_value;
  } req_item_t;

  typedef struct packed {
    status_t              status;
    logic [VALUE_W-1:0]   found_value;
    logic [ENTRY_W-1:0]   entry_count;
  } rsp_item_t;

  // item held still while its token walks the row
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic               write_ok;
  } query_t;

  // token handed from cell to cell
  typedef struct packed {
    logic               active;
    logic               hit;
    logic               added;
    logic [VALUE_W-1:0] found;
  } tok_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_RUN    = 2'd1,
    S_FINISH = 2'd2
  } state_t;

endpackage

[rtl/nkvt_cell.sv]
// ---------------------------------------------------------------------------
// nkvt_cell: one table entry
// holds one name and value, compares against the query as the token passes,
// updates or claims itself and hands the token to the next cell
// ---------------------------------------------------------------------------
module nkvt_cell #(
  parameter int INDEX   = 0,
  parameter int COUNT_W = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  nkvt_pkg::query_t     query,
  input  logic [COUNT_W-1:0]   count,
  input  nkvt_pkg::tok_t       tok_in,
  output nkvt_pkg::tok_t       tok_out
);

  logic [nkvt_pkg::KEY_W-1:0]   key;
  logic [nkvt_pkg::VALUE_W-1:0] value;
  logic                         used;
  logic                         free_slot;
  logic                         match;
  logic                         do_update;
  logic                         do_append;
  nkvt_pkg::tok_t               tok_next;

  assign used      = COUNT_W'(INDEX) < count;
  assign free_slot = COUNT_W'(INDEX) == count;
  assign match     = used && (key == query.key);
  assign do_update = tok_in.active && match && query.write_ok;
  assign do_append = tok_in.active && !tok_in.hit && free_slot && query.write_ok;

  always_comb begin
    tok_next        = tok_in;
    tok_next.hit    = tok_in.hit || match;
    tok_next.added  = tok_in.added || do_append;
    tok_next.found  = match ? value : tok_in.found;
  end

  always_ff @(posedge clk) begin
    if (do_append) begin
      key   <= query.key;
      value <= query.value;
    end else if (do_update) begin
      value <= query.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out.active <= tok_next.active;
    end
    tok_out.hit   <= tok_next.hit;
    tok_out.added <= tok_next.added;
    tok_out.found <= tok_next.found;
  end

endmodule

[rtl/name_keyed_value_table.sv]
// ---------------------------------------------------------------------------
// name_keyed_value_table: bounded table of names to 64-bit values
// a row of entry cells searched by a token that walks one cell per cycle
// ---------------------------------------------------------------------------
// req carries one item: an insert (op 0) or a lookup (op 1) of a name given
// as four 64-bit words, nul padded, and the value to store on insert.
// rsp carries one item per request: status, the found value on a lookup hit
// and the number of entries held after the item.
// the name is trimmed at its first nul and captured; a token then walks the
// row of CAPACITY cells, one cell per cycle. a matching cell reports its
// value or takes the new value, the first free cell takes a new name.
// the req is registered into the captured item and start; the token then
// passes the register of each cell, the tail is latched and rsp is loaded.
// one item is in flight at a time: no new req is taken until rsp is loaded.
// req_stall is high while an item is in flight. when rsp_stall holds the
// result, the block waits with it and takes no new req until it is loaded
// into the output register.
// reset clears the entry count and all control state; stored names and
// values are left as they are and are never read before being written.
// ---------------------------------------------------------------------------
module name_keyed_value_table #(
  parameter int CAPACITY   = 64,
  parameter int NAME_BYTES = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  nkvt_pkg::req_item_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output nkvt_pkg::rsp_item_t rsp
);

  localparam int COUNT_W = $clog2(CAPACITY + 1);

  nkvt_pkg::state_t   state;
  nkvt_pkg::state_t   state_next;
  nkvt_pkg::query_t   query;
  logic               is_lookup;
  logic               is_invalid;
  logic               start;
  logic [COUNT_W-1:0] count;
  nkvt_pkg::tok_t     tail;
  nkvt_pkg::tok_t     tok [CAPACITY+1];
  nkvt_pkg::status_t  status;
  logic               accept;
  logic               latch_tail;
  logic               load_rsp;
  logic [nkvt_pkg::KEY_W-1:0] canon_key;

  function automatic logic [nkvt_pkg::KEY_W-1:0] canon(input nkvt_pkg::req_item_t it);
    logic [nkvt_pkg::KEY_W-1:0] raw;
    logic [nkvt_pkg::KEY_W-1:0] res;
    logic                       ended;
    raw   = {it.key_word3, it.key_word2, it.key_word1, it.key_word0};
    res   = '0;
    ended = 1'b0;
    for (int b = 0; b < nkvt_pkg::KEY_W / 8; b++) begin
      if (b >= NAME_BYTES || raw[8*b +: 8] == 8'h00) begin
        ended = 1'b1;
      end
      if (!ended) begin
        res[8*b +: 8] = raw[8*b +: 8];
      end
    end
    return res;
  endfunction

  assign canon_key = canon(req);
  assign accept    = req_valid && !req_stall;

  always_comb begin
    state_next = state;
    case (state)
      nkvt_pkg::S_IDLE: begin
        if (accept) state_next = nkvt_pkg::S_RUN;
      end
      nkvt_pkg::S_RUN: begin
        if (tok[CAPACITY].active) state_next = nkvt_pkg::S_FINISH;
      end
      nkvt_pkg::S_FINISH: begin
        if (!rsp_valid || !rsp_stall) state_next = nkvt_pkg::S_IDLE;
      end
      default: state_next = nkvt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_stall  = 1'b1;
    latch_tail = 1'b0;
    load_rsp   = 1'b0;
    case (state)
      nkvt_pkg::S_IDLE:   req_stall = 1'b0;
      nkvt_pkg::S_RUN:    latch_tail = tok[CAPACITY].active;
      nkvt_pkg::S_FINISH: load_rsp = !rsp_valid || !rsp_stall;
      default:            req_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= nkvt_pkg::S_IDLE;
      start     <= 1'b0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      start <= accept;
      if (latch_tail && tok[CAPACITY].added) begin
        count <= count + COUNT_W'(1);
      end
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // captured item
  always_ff @(posedge clk) begin
    if (accept) begin
      query.key      <= canon_key;
      query.value    <= req.new_value;
      query.write_ok <= (req.op == nkvt_pkg::OP_INSERT) && (canon_key[7:0] != 8'h00)
                        && (req.new_value != '0);
      is_lookup      <= req.op == nkvt_pkg::OP_LOOKUP;
      is_invalid     <= (canon_key[7:0] == 8'h00) || (req.new_value == '0);
    end
    if (latch_tail) begin
      tail <= tok[CAPACITY];
    end
  end

  always_comb begin
    if (is_lookup) begin
      status = tail.hit ? nkvt_pkg::ST_HIT : nkvt_pkg::ST_MISS;
    end else if (is_invalid) begin
      status = nkvt_pkg::ST_INVALID;
    end else if (tail.hit) begin
      status = nkvt_pkg::ST_UPDATED;
    end else if (tail.added) begin
      status = nkvt_pkg::ST_ADDED;
    end else begin
      status = nkvt_pkg::ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.status      <= status;
      rsp.found_value <= (is_lookup && tail.hit) ? tail.found : '0;
      rsp.entry_count <= nkvt_pkg::ENTRY_W'(count);
    end
  end

  always_comb begin
    tok[0]        = '0;
    tok[0].active = start;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    nkvt_cell #(
      .INDEX   (i),
      .COUNT_W (COUNT_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .query   (query),
      .count   (count),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

endmodule
